// ===== rtl/core/twsm_pkg.sv =====
// ----------------------------------------------------------------------------
// twsm_pkg
// Shared types, codes and helpers for the three-wire serial master core.
// ----------------------------------------------------------------------------
package twsm_pkg;

  // Width of the phase delay counter
  localparam int DELAY_BITS = 10;
  localparam int HALF_W     = 10;
  localparam int SETUP_W    = 8;
  localparam int CFG_DATA_W = 10;
  localparam int PHASE_W    = 4;
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef enum logic [2:0] {
    OP_BEGIN = 3'd0,
    OP_WRITE = 3'd1,
    OP_READ  = 3'd2,
    OP_END   = 3'd3,
    OP_TICK  = 3'd4
  } opcode_t;

  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE     = 4'd0,
    PH_BEGIN_A  = 4'd1,
    PH_BEGIN_B  = 4'd2,
    PH_BIT_LOW  = 4'd3,
    PH_BIT_HIGH = 4'd4,
    PH_END_A    = 4'd5,
    PH_END_B    = 4'd6
  } phase_t;

  typedef enum logic {
    CFG_HALF_BIT = 1'b0,
    CFG_CS_SETUP = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] write_data;
    logic       sio_sample;
  } in_item_t;

  typedef struct packed {
    logic       cs_level;
    logic       sck_level;
    logic       sio_drive;
    logic       sio_level;
    logic       busy_res;
    logic       read_valid;
    logic [7:0] read_data;
    logic       rejected;
  } out_item_t;

  typedef struct packed {
    logic [HALF_W-1:0]  half_bit_ticks;
    logic [SETUP_W-1:0] cs_setup_ticks;
  } cfg_t;

  // Load value for the delay counter: zero counts as one, clamp at the top
  function automatic logic [DELAY_BITS-1:0] delay_load(input logic [HALF_W-1:0] v);
    logic [16:0] vw;
    logic [16:0] top;
    vw  = 17'(v);
    top = 17'((1 << DELAY_BITS) - 1);
    if (vw == 17'd0) begin
      vw = 17'd1;
    end
    if (vw > top) begin
      vw = top;
    end
    return vw[DELAY_BITS-1:0];
  endfunction

endpackage

// ===== rtl/core/twsm_seq.sv =====
// ----------------------------------------------------------------------------
// twsm_seq
// Frame sequencer: pin levels, bit shifter and phase timer, updated once per
// accepted item, with the result of that item formed combinationally.
// ----------------------------------------------------------------------------
module twsm_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_acc,
  input  twsm_pkg::in_item_t  item,
  input  twsm_pkg::cfg_t      cfg,
  output twsm_pkg::out_item_t result
);
  import twsm_pkg::*;

  phase_t                phase_r, phase_nxt;
  logic [7:0]            shift_r, shift_nxt;
  logic [3:0]            bits_r, bits_nxt;
  logic [DELAY_BITS-1:0] delay_r, delay_nxt;
  logic                  cs_r, cs_nxt;
  logic                  sck_r, sck_nxt;
  logic                  drv_r, drv_nxt;
  logic                  lvl_r, lvl_nxt;
  logic                  reading_r, reading_nxt;

  logic                  idle;
  logic                  is_cmd;
  logic                  tick_fire;
  logic                  phase_done;
  logic                  last_bit;
  logic [DELAY_BITS-1:0] dly_dec;
  logic [3:0]            bits_dec;
  logic [7:0]            shift_adv;
  logic [DELAY_BITS-1:0] half_load;
  logic [DELAY_BITS-1:0] setup_load;

  // Decode the item against the current phase
  always_comb begin
    idle       = (phase_r == PH_IDLE);
    is_cmd     = (item.opcode < OP_TICK);
    tick_fire  = (item.opcode == OP_TICK) && !idle;
    dly_dec    = (delay_r != '0) ? delay_r - 1'b1 : '0;
    phase_done = tick_fire && (dly_dec == '0);
    bits_dec   = (bits_r != 4'd0) ? bits_r - 4'd1 : 4'd0;
    shift_adv  = {shift_r[6:0], reading_r & item.sio_sample};
    last_bit   = phase_done && (phase_r == PH_BIT_HIGH) && (bits_dec == 4'd0);
    half_load  = delay_load(cfg.half_bit_ticks);
    setup_load = delay_load(HALF_W'(cfg.cs_setup_ticks));
  end

  // Next state
  always_comb begin
    phase_nxt   = phase_r;
    shift_nxt   = shift_r;
    bits_nxt    = bits_r;
    delay_nxt   = delay_r;
    cs_nxt      = cs_r;
    sck_nxt     = sck_r;
    drv_nxt     = drv_r;
    lvl_nxt     = lvl_r;
    reading_nxt = reading_r;
    if (is_cmd && idle) begin
      case (item.opcode)
        OP_BEGIN: begin
          cs_nxt    = 1'b0;
          sck_nxt   = 1'b1;
          drv_nxt   = 1'b1;
          lvl_nxt   = 1'b1;
          phase_nxt = PH_BEGIN_A;
          delay_nxt = setup_load;
        end
        OP_WRITE, OP_READ: begin
          reading_nxt = (item.opcode == OP_READ);
          shift_nxt   = reading_nxt ? 8'd0 : item.write_data;
          bits_nxt    = BITS_PER_BYTE;
          cs_nxt      = 1'b1;
          sck_nxt     = 1'b0;
          drv_nxt     = !reading_nxt;
          lvl_nxt     = !reading_nxt && shift_nxt[7];
          phase_nxt   = PH_BIT_LOW;
          delay_nxt   = half_load;
        end
        default: begin
          phase_nxt = PH_END_A;
          delay_nxt = setup_load;
        end
      endcase
    end else if (tick_fire) begin
      delay_nxt = dly_dec;
      if (phase_done) begin
        case (phase_r)
          PH_BEGIN_A: begin
            cs_nxt    = 1'b1;
            sck_nxt   = 1'b1;
            drv_nxt   = 1'b1;
            lvl_nxt   = 1'b1;
            phase_nxt = PH_BEGIN_B;
            delay_nxt = setup_load;
          end
          PH_BIT_LOW: begin
            sck_nxt   = 1'b1;
            phase_nxt = PH_BIT_HIGH;
            delay_nxt = half_load;
          end
          PH_BIT_HIGH: begin
            shift_nxt = shift_adv;
            bits_nxt  = bits_dec;
            if (bits_dec == 4'd0) begin
              phase_nxt = PH_IDLE;
            end else begin
              cs_nxt    = 1'b1;
              sck_nxt   = 1'b0;
              drv_nxt   = !reading_r;
              lvl_nxt   = !reading_r && shift_adv[7];
              phase_nxt = PH_BIT_LOW;
              delay_nxt = half_load;
            end
          end
          PH_END_A: begin
            cs_nxt    = 1'b0;
            sck_nxt   = 1'b1;
            drv_nxt   = 1'b0;
            lvl_nxt   = 1'b0;
            phase_nxt = PH_END_B;
            delay_nxt = setup_load;
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end
    end
  end

  // Result of the item: pins after the update plus status flags
  always_comb begin
    result.cs_level   = cs_nxt;
    result.sck_level  = sck_nxt;
    result.sio_drive  = drv_nxt;
    result.sio_level  = lvl_nxt;
    result.busy_res   = (phase_nxt != PH_IDLE);
    result.read_valid = last_bit && reading_r;
    result.read_data  = (last_bit && reading_r) ? shift_adv : 8'd0;
    result.rejected   = is_cmd && !idle;
  end

  // Advance the state on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      shift_r   <= 8'd0;
      bits_r    <= 4'd0;
      delay_r   <= '0;
      cs_r      <= 1'b0;
      sck_r     <= 1'b1;
      drv_r     <= 1'b0;
      lvl_r     <= 1'b0;
      reading_r <= 1'b0;
    end else if (item_acc) begin
      phase_r   <= phase_nxt;
      shift_r   <= shift_nxt;
      bits_r    <= bits_nxt;
      delay_r   <= delay_nxt;
      cs_r      <= cs_nxt;
      sck_r     <= sck_nxt;
      drv_r     <= drv_nxt;
      lvl_r     <= lvl_nxt;
      reading_r <= reading_nxt;
    end
  end

endmodule

// ===== rtl/core/three_wire_serial_master_core.sv =====
// An accepted item's result is registered in the output register, or in the skid entry while the output stalls.
// Throughput: one item per cycle while in_stall is low; the sequencer state updates in one pass.
// A two-entry output (register plus skid) keeps in_stall registered.
// Reset (rst_n low, synchronous): idle, CS low, SCK high, line released,
// half_bit_ticks 9, cs_setup_ticks 2, no result pending.
// ----------------------------------------------------------------------------
// three_wire_serial_master_core
// Three-wire serial master with configuration registers and buffered output.
// ----------------------------------------------------------------------------
module three_wire_serial_master_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  twsm_pkg::in_item_t                   in_item,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output twsm_pkg::out_item_t                  out_item,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic                                 cfg_index,
  input  logic [twsm_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import twsm_pkg::*;

  cfg_t      cfg_r;
  out_item_t result;
  out_item_t out_item_r;
  out_item_t skid_item_r;
  logic      out_valid_r;
  logic      skid_valid_r;
  logic      in_acc;
  logic      out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign in_acc    = in_valid && !skid_valid_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Hold the configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_bit_ticks <= HALF_W'(9);
      cfg_r.cs_setup_ticks <= SETUP_W'(2);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_HALF_BIT: cfg_r.half_bit_ticks <= cfg_data[HALF_W-1:0];
        CFG_CS_SETUP: cfg_r.cs_setup_ticks <= cfg_data[SETUP_W-1:0];
        default:      cfg_r <= cfg_r;
      endcase
    end
  end

  twsm_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .item_acc (in_acc),
    .item     (in_item),
    .cfg      (cfg_r),
    .result   (result)
  );

  // Move result items through the output register and skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_acc;
      end
    end else if (in_acc) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_item_r <= skid_item_r;
      end else if (in_acc) begin
        out_item_r <= result;
      end
    end else if (in_acc) begin
      skid_item_r <= result;
    end
  end

endmodule

// ===== rtl/core/twsm_checker.sv =====
// ----------------------------------------------------------------------------
// twsm_port_checker
// Port-level checks on the three-wire serial master core.
// ----------------------------------------------------------------------------
module twsm_port_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_valid,
  input logic                            out_stall,
  input twsm_pkg::out_item_t             out_item
);
  import twsm_pkg::*;

  // Hold a stalled result item
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result item changed");

  // A completed read ends the sequence
  a_read_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.read_valid |-> !out_item.busy_res && !out_item.rejected)
    else $error("read completed while still busy");

  // Read data is zero unless a read completes
  a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.read_valid |-> out_item.read_data == 8'd0)
    else $error("read data without read valid");

  // A released line carries level zero
  a_sio_released: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.sio_drive |-> !out_item.sio_level)
    else $error("level shown on released data line");

  // A rejected command leaves the sequence running
  a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.rejected |-> out_item.busy_res)
    else $error("rejected command while idle");

endmodule

bind three_wire_serial_master_core twsm_port_checker u_twsm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

// ===== verif/twsm_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// twsm_checker
// Watches the command, result and register channels of the three-wire serial
// master, predicts every result item from its own copy of the sequencer and
// compares the result items field by field in order.
// ----------------------------------------------------------------------------
module twsm_checker
  import twsm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_item_t              in_item,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_item_t             out_item,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending,
  output logic                  seq_busy
);

  // Predicted sequencer state and timing registers
  phase_t             line_phase;
  logic [7:0]         shift_reg;
  logic [3:0]         bits_remaining;
  logic [9:0]         tick_count;
  logic               cs_pin, sck_pin, drv_pin, lvl_pin;
  logic               is_read;
  logic [HALF_W-1:0]  half_ticks;
  logic [SETUP_W-1:0] setup_ticks;

  // Result items expected in order of acceptance
  out_item_t expected_pins[$];

  // A zero count still lasts one tick; a 10-bit count never exceeds the counter
  function automatic logic [9:0] load_ticks(input logic [9:0] v);
    return (v == '0) ? 10'd1 : v;
  endfunction

  // Start the low half of the next bit: present data unless reading
  function automatic void enter_bit_low();
    cs_pin     = 1'b1;
    sck_pin    = 1'b0;
    drv_pin    = !is_read;
    lvl_pin    = !is_read && shift_reg[7];
    line_phase = PH_BIT_LOW;
    tick_count = load_ticks(half_ticks);
  endfunction

  // Apply one item to the predicted sequencer and return the expected result
  function automatic out_item_t step_line(input in_item_t it);
    out_item_t r;
    r = '0;
    if (it.opcode <= OP_END) begin
      if (line_phase != PH_IDLE) begin
        r.rejected = 1'b1;
      end else begin
        case (it.opcode)
          OP_BEGIN: begin
            cs_pin     = 1'b0;
            sck_pin    = 1'b1;
            drv_pin    = 1'b1;
            lvl_pin    = 1'b1;
            line_phase = PH_BEGIN_A;
            tick_count = load_ticks(10'(setup_ticks));
          end
          OP_WRITE, OP_READ: begin
            is_read        = (it.opcode == OP_READ);
            shift_reg      = is_read ? 8'h00 : it.write_data;
            bits_remaining = BITS_PER_BYTE;
            enter_bit_low();
          end
          OP_END: begin
            line_phase = PH_END_A;
            tick_count = load_ticks(10'(setup_ticks));
          end
          default: ;
        endcase
      end
    end else if (it.opcode == OP_TICK && line_phase != PH_IDLE) begin
      if (tick_count != '0) tick_count--;
      if (tick_count == '0) begin
        case (line_phase)
          PH_BEGIN_A: begin
            cs_pin     = 1'b1;
            sck_pin    = 1'b1;
            drv_pin    = 1'b1;
            lvl_pin    = 1'b1;
            line_phase = PH_BEGIN_B;
            tick_count = load_ticks(10'(setup_ticks));
          end
          PH_BIT_LOW: begin
            sck_pin    = 1'b1;
            line_phase = PH_BIT_HIGH;
            tick_count = load_ticks(half_ticks);
          end
          PH_BIT_HIGH: begin
            // Sample the line at the close of the high half
            shift_reg = {shift_reg[6:0], is_read ? it.sio_sample : 1'b0};
            if (bits_remaining != '0) bits_remaining--;
            if (bits_remaining == '0) begin
              line_phase = PH_IDLE;
              if (is_read) begin
                r.read_valid = 1'b1;
                r.read_data  = shift_reg;
              end
            end else begin
              enter_bit_low();
            end
          end
          PH_END_A: begin
            cs_pin     = 1'b0;
            sck_pin    = 1'b1;
            drv_pin    = 1'b0;
            lvl_pin    = 1'b0;
            line_phase = PH_END_B;
            tick_count = load_ticks(10'(setup_ticks));
          end
          default: line_phase = PH_IDLE;
        endcase
      end
    end
    r.cs_level  = cs_pin;
    r.sck_level = sck_pin;
    r.sio_drive = drv_pin;
    r.sio_level = lvl_pin;
    r.busy_res  = (line_phase != PH_IDLE);
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      line_phase     = PH_IDLE;
      shift_reg      = '0;
      bits_remaining = '0;
      tick_count     = '0;
      cs_pin         = 1'b0;
      sck_pin        = 1'b1;
      drv_pin        = 1'b0;
      lvl_pin        = 1'b0;
      is_read        = 1'b0;
      half_ticks     = 10'd9;
      setup_ticks    = 8'd2;
      fail_count     = 0;
      expected_pins.delete();
    end else begin
      // Compare a delivered result with the oldest prediction
      if (out_valid && !out_stall) begin
        if (expected_pins.size() == 0) begin
          $error("result item arrived with no item outstanding");
          fail_count++;
        end else begin
          want = expected_pins.pop_front();
          check_field("cs_level",   want.cs_level,   out_item.cs_level);
          check_field("sck_level",  want.sck_level,  out_item.sck_level);
          check_field("sio_drive",  want.sio_drive,  out_item.sio_drive);
          check_field("sio_level",  want.sio_level,  out_item.sio_level);
          check_field("busy_res",   want.busy_res,   out_item.busy_res);
          check_field("read_valid", want.read_valid, out_item.read_valid);
          check_field("read_data",  want.read_data,  out_item.read_data);
          check_field("rejected",   want.rejected,   out_item.rejected);
        end
      end
      // Track register writes
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_HALF_BIT) half_ticks = cfg_data[HALF_W-1:0];
        else setup_ticks = cfg_data[SETUP_W-1:0];
      end
      // Predict the result of each accepted command or tick
      if (in_valid && !in_stall) expected_pins.push_back(step_line(in_item));
    end
    pending  = expected_pins.size();
    seq_busy = (line_phase != PH_IDLE);
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives the three-wire serial master with frames of begin, byte and end
// commands interleaved with tick items, plus rejected and unused commands,
// across several timing settings with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module tb;
  import twsm_pkg::*;

  // Opcodes the block ignores
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam int         RANDOM_ITEMS = 300;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_item;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_item;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic                  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int   fail_count;
  int   pending;
  logic seq_busy;
  int   live_items;
  logic tx_idle;
  logic rx_idle;

  three_wire_serial_master_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  twsm_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending),
    .seq_busy   (seq_busy)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bias bytes toward all zeros and all ones
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Send one item; entered and left at a falling edge, valid held after accept
  task automatic send_op(input logic [2:0] op, input logic [7:0] wd);
    int gap;
    gap = tx_idle ? $urandom_range(0, 9) : 0;
    if (seq_busy ? (op == OP_TICK) : (op <= OP_END)) live_items++;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid           = 1'b1;
    in_item.opcode     = op;
    in_item.write_data = wd;
    in_item.sio_sample = 1'($urandom);
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Hold the sender until every outstanding result has come back
  task automatic drain();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // Write both timing registers back to back; only while drained
  task automatic set_timing(input logic [CFG_DATA_W-1:0] half,
                            input logic [CFG_DATA_W-1:0] setup);
    cfg_valid = 1'b1;
    cfg_index = CFG_HALF_BIT;
    cfg_data  = half;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_index = CFG_CS_SETUP;
    cfg_data  = setup;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Tick until the sequence completes, with stray commands and pauses mixed in
  task automatic finish_seq();
    while (seq_busy) begin
      case ($urandom_range(0, 39))
        0:       send_op(3'($urandom_range(OP_BEGIN, OP_END)), pick_byte());
        1:       send_op(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), pick_byte());
        2:       drain();
        default: send_op(OP_TICK, 8'($urandom));
      endcase
    end
  endtask

  task automatic run_frame(input int n_bytes);
    send_op(OP_BEGIN, pick_byte());
    finish_seq();
    repeat (n_bytes) begin
      send_op($urandom_range(0, 1) ? OP_WRITE : OP_READ, pick_byte());
      finish_seq();
    end
    send_op(OP_END, pick_byte());
    finish_seq();
  endtask

  // Result side: draw a stall for every accepted result item
  initial begin
    int hold;
    hold      = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall = (hold > 0);
      if (hold > 0) hold--;
      @(posedge clk);
      if (out_valid && !out_stall) hold = rx_idle ? $urandom_range(0, 9) : 0;
    end
  end

  // Command side and verdict
  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_item    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_HALF_BIT;
    cfg_data   = '0;
    tx_idle    = 1'b1;
    rx_idle    = 1'b1;
    live_items = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Idle tick and unused opcodes change nothing
    send_op(OP_TICK, 8'hFF);
    send_op(OP_SPARE_LO, 8'h00);
    send_op(OP_SPARE_HI, 8'hFF);
    // Begin at reset timing; commands during the sequence are rejected
    send_op(OP_BEGIN, 8'h00);
    send_op(OP_WRITE, 8'hA5);
    send_op(OP_END, 8'h5A);
    repeat (4) send_op(OP_TICK, 8'($urandom));
    send_op(OP_END, 8'h00);
    repeat (4) send_op(OP_TICK, 8'($urandom));
    // Write outside a frame at reset half-bit timing
    send_op(OP_WRITE, 8'h81);
    finish_seq();

    // Zero registers behave as one tick
    drain();
    set_timing('0, '0);
    send_op(OP_BEGIN, 8'hFF);
    repeat (2) send_op(OP_TICK, 8'($urandom));
    send_op(OP_END, 8'h00);
    repeat (2) send_op(OP_TICK, 8'($urandom));

    // Long timing on both registers, one read byte, no idling
    drain();
    set_timing(10'd12, 10'd30);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    send_op(OP_BEGIN, pick_byte());
    finish_seq();
    send_op(OP_READ, pick_byte());
    finish_seq();
    send_op(OP_END, pick_byte());
    finish_seq();

    // Random phases with short timing
    live_items = 0;
    while (live_items < RANDOM_ITEMS) begin
      drain();
      set_timing(10'($urandom_range(0, 3)),
                 {2'($urandom), ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 40))
                                                           : 8'($urandom_range(0, 3))});
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 4) == 0) begin
          // noise: any opcode, including bytes outside a frame
          repeat ($urandom_range(3, 8)) begin
            send_op(3'($urandom), pick_byte());
            finish_seq();
          end
        end else begin
          run_frame($urandom_range(1, 3));
        end
      end
    end

    drain();
    repeat (8) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(15_000_000);
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/twsm_pkg.sv
rtl/core/twsm_seq.sv
rtl/core/three_wire_serial_master_core.sv
rtl/core/twsm_checker.sv
verif/twsm_checker.sv
verif/tb.sv
